// File: hdl/ntc_pkg.sv
// Shared constants, types and the resistance table of the NTC thermometer.
`default_nettype none

package ntc_pkg;

   // Field widths
   localparam int SAMPLE_W = 12;
   localparam int RES_W    = 20;
   localparam int FS_W     = 12;
   localparam int CNT_W    = 5;
   localparam int TEMP_W   = 15;
   localparam int SUM_W    = 16;
   localparam int ROM_W    = 16;
   localparam int PROD_W   = FS_W + RES_W;
   localparam int FRAC_W   = 9;
   localparam int STEP_W   = 5;

   // Configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 20;

   // Table geometry: entries in use, clamped between 2 and what the table stores
   localparam int TABLE_ENTRIES = 61;
   localparam int ROM_SIZE      = 61;
   localparam int ENTRY_COUNT   = (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE :
                                  ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
   localparam int IDX_W         = $clog2(ROM_SIZE);
   localparam int TEMP_OFFSET_C = 10;

   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ENTRY_COUNT - 1);
   localparam logic [RES_W-1:0]  RES_MAX  = {RES_W{1'b1}};
   localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(16);
   localparam logic [TEMP_W-1:0] TEMP_OFFSET_Q8 = TEMP_W'(TEMP_OFFSET_C * 256);

   // Divider step counts, loaded as count minus one
   localparam logic [STEP_W-1:0] AVG_STEPS  = STEP_W'(SUM_W - 1);
   localparam logic [STEP_W-1:0] RES_STEPS  = STEP_W'(RES_W - 1);
   localparam logic [STEP_W-1:0] FRAC_STEPS = STEP_W'(FRAC_W - 1);

   // Reset values of the configuration registers
   localparam logic [RES_W-1:0] FIXED_RES_RESET    = RES_W'(10000);
   localparam logic [FS_W-1:0]  FULL_SCALE_RESET   = FS_W'(3300);
   localparam logic [CNT_W-1:0] SAMPLE_COUNT_RESET = CNT_W'(10);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FIXED_RES    = 2'd0,
      CSR_FULL_SCALE   = 2'd1,
      CSR_SAMPLE_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AVG_DIV,
      ST_SCALE,
      ST_OVF,
      ST_RES_DIV,
      ST_RANGE,
      ST_SEARCH,
      ST_FRAC_DIV,
      ST_FINISH
   } state_type;

   // Resistance in ohms at (index - 10) C, falling with index
   function automatic logic [ROM_W-1:0] ntc_rom(input logic [IDX_W-1:0] idx);
      logic [ROM_W-1:0] r;
      case (idx)
         6'd0:  r = 16'd51815;  6'd1:  r = 16'd49283;  6'd2:  r = 16'd46889;
         6'd3:  r = 16'd44624;  6'd4:  r = 16'd42481;  6'd5:  r = 16'd40450;
         6'd6:  r = 16'd38526;  6'd7:  r = 16'd36702;  6'd8:  r = 16'd34971;
         6'd9:  r = 16'd33329;  6'd10: r = 16'd31770;  6'd11: r = 16'd30253;
         6'd12: r = 16'd28815;  6'd13: r = 16'd27453;  6'd14: r = 16'd26160;
         6'd15: r = 16'd24935;  6'd16: r = 16'd23772;  6'd17: r = 16'd22668;
         6'd18: r = 16'd21620;  6'd19: r = 16'd20626;  6'd20: r = 16'd19681;
         6'd21: r = 16'd18784;  6'd22: r = 16'd17932;  6'd23: r = 16'd17122;
         6'd24: r = 16'd16353;  6'd25: r = 16'd15621;  6'd26: r = 16'd14925;
         6'd27: r = 16'd14263;  6'd28: r = 16'd13634;  6'd29: r = 16'd13035;
         6'd30: r = 16'd12465;  6'd31: r = 16'd11922;  6'd32: r = 16'd11406;
         6'd33: r = 16'd10914;  6'd34: r = 16'd10446;  6'd35: r = 16'd10000;
         6'd36: r = 16'd9574;   6'd37: r = 16'd9169;   6'd38: r = 16'd8783;
         6'd39: r = 16'd8415;   6'd40: r = 16'd8064;   6'd41: r = 16'd7729;
         6'd42: r = 16'd7410;   6'd43: r = 16'd7105;   6'd44: r = 16'd6814;
         6'd45: r = 16'd6537;   6'd46: r = 16'd6272;   6'd47: r = 16'd6019;
         6'd48: r = 16'd5778;   6'd49: r = 16'd5547;   6'd50: r = 16'd5327;
         6'd51: r = 16'd5116;   6'd52: r = 16'd4915;   6'd53: r = 16'd4722;
         6'd54: r = 16'd4539;   6'd55: r = 16'd4363;   6'd56: r = 16'd4195;
         6'd57: r = 16'd4034;   6'd58: r = 16'd3880;   6'd59: r = 16'd3733;
         6'd60: r = 16'd3592;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Temperature of a table entry in signed Q7.8 (8 fraction bits)
   function automatic logic signed [TEMP_W-1:0] entry_temp(input logic [IDX_W-1:0] idx);
      logic [TEMP_W-1:0] t;
      t = TEMP_W'({idx, 8'h00}) - TEMP_OFFSET_Q8;
      return $signed(t);
   endfunction

endpackage

`default_nettype wire

// File: hdl/ntc_if.sv
// Valid/ready channels of the NTC thermometer: sample words in, result words out.
`default_nettype none

interface ntc_req_if;
   import ntc_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_mv;
   modport source (output valid, output sample_mv, input ready);
   modport sink   (input valid, input sample_mv, output ready);
endinterface

interface ntc_rsp_if;
   import ntc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_q8;
   logic [RES_W-1:0]         resistance_ohms;
   logic                     out_of_range;
   modport source (output valid, output temperature_q8, output resistance_ohms,
                   output out_of_range, input ready);
   modport sink   (input valid, input temperature_q8, input resistance_ohms,
                   input out_of_range, output ready);
endinterface

`default_nettype wire

// File: hdl/ntc_thermistor_temperature.sv
// NTC thermometer: sample averaging, divider resistance and table interpolation.
//
//   channel   dir  word                                            handshake
//   req_ch    in   sample_mv                                       valid/ready
//   rsp_ch    out  temperature_q8, resistance_ohms, out_of_range   valid/ready
//   csr_*     in   csr_index, csr_wdata                            csr_we, no stall
//
// A sample that does not close a group is only added to the running sum. The
// closing sample spends most of its time in one shared radix-2 divider: 16 steps
// for the average, 20 for the resistance, 9 for the interpolation fraction, plus up to
// six binary-search steps over the table. req_ch.ready is low while a result is
// being worked out; a finished word waits in the output register and only the
// next closing sample stalls behind it. Reset is synchronous and restores the
// register defaults and clears the running sum.
`default_nettype none

module ntc_thermistor_temperature (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ntc_req_if.sink                             req_ch,
   ntc_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [ntc_pkg::CSR_ADDR_W-1:0] csr_index,
   input  wire logic [ntc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ntc_pkg::*;

   // Configuration
   logic [RES_W-1:0] fixed_res_ff;
   logic [FS_W-1:0]  full_scale_ff;
   logic [CNT_W-1:0] sample_count_ff;

   // Accumulator
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   // Sequencer and shared divider
   state_type         state_ff, state_in;
   logic [ROM_W-1:0]  rem_ff, rem_in;
   logic [RES_W-1:0]  dvd_ff, dvd_in;
   logic [ROM_W-1:0]  dsr_ff, dsr_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Working values
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [FS_W-1:0]          den_ff, den_in;
   logic [RES_W-1:0]         res_ff, res_in;
   logic [IDX_W-1:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic                     oor_ff, oor_in;

   // Output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0] rsp_temp_ff;
   logic [RES_W-1:0]         rsp_res_ff;
   logic                     rsp_oor_ff;

   // Handshake and decode
   logic             req_take, rsp_load;
   logic [CNT_W-1:0] cnt_eff;
   logic [SUM_W-1:0] sum_add;
   logic [CNT_W-1:0] idx_add;
   logic             group_done;

   // Divider step
   logic [ROM_W:0]   div_trial, div_diff;
   logic             div_ge;
   logic [ROM_W-1:0] rem_next;
   logic [RES_W-1:0] dvd_next;

   // Search and range
   logic [SUM_W-1:0] avg;
   logic             volt_sat, res_ovf;
   logic [IDX_W:0]   lo_hi_sum;
   logic [IDX_W-1:0] mid;
   logic [IDX_W-1:0] span;
   logic [ROM_W-1:0] rom_lo, rom_hi, rom_mid, frac_num;

   // Sample count clamped to 1..16
   always_comb begin
      if (sample_count_ff == '0) begin
         cnt_eff = CNT_W'(1);
      end else if (sample_count_ff > CNT_MAX) begin
         cnt_eff = CNT_MAX;
      end else begin
         cnt_eff = sample_count_ff;
      end
   end

   assign sum_add    = sum_ff + SUM_W'(req_ch.sample_mv);
   assign idx_add    = idx_ff + CNT_W'(1);
   assign group_done = (idx_add >= cnt_eff);

   // One restoring divide step: shift a dividend bit into the remainder
   assign div_trial = {rem_ff, dvd_ff[RES_W-1]};
   assign div_diff  = div_trial - {1'b0, dsr_ff};
   assign div_ge    = (div_trial >= {1'b0, dsr_ff});
   assign rem_next  = div_ge ? div_diff[ROM_W-1:0] : div_trial[ROM_W-1:0];
   assign dvd_next  = {dvd_ff[RES_W-2:0], div_ge};

   // Saturation checks and table reads
   assign avg       = dvd_ff[SUM_W-1:0];
   assign volt_sat  = (avg >= SUM_W'(full_scale_ff));
   assign res_ovf   = (prod_ff >= {den_ff, {RES_W{1'b0}}});
   assign lo_hi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = lo_hi_sum[IDX_W:1];
   assign span      = hi_ff - lo_ff;
   assign rom_lo    = ntc_rom(lo_ff);
   assign rom_hi    = ntc_rom(hi_ff);
   assign rom_mid   = ntc_rom(mid);
   assign frac_num  = rom_lo - res_ff[ROM_W-1:0];

   // Handshake outputs
   always_comb begin
      req_take     = (state_ff == ST_IDLE) && req_ch.valid;
      rsp_load     = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.temperature_q8 = rsp_temp_ff;
   assign rsp_ch.resistance_ohms = rsp_res_ff;
   assign rsp_ch.out_of_range   = rsp_oor_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && group_done) state_in = ST_AVG_DIV;
         end
         ST_AVG_DIV: begin
            if (step_ff == '0) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = volt_sat ? ST_FINISH : ST_OVF;
         end
         ST_OVF: begin
            state_in = res_ovf ? ST_RANGE : ST_RES_DIV;
         end
         ST_RES_DIV: begin
            if (step_ff == '0) state_in = ST_RANGE;
         end
         ST_RANGE: begin
            if (res_ff > RES_W'(ntc_rom('0)) || res_ff < RES_W'(ntc_rom(LAST_IDX))) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (span <= IDX_W'(1)) state_in = ST_FRAC_DIV;
         end
         ST_FRAC_DIV: begin
            if (step_ff == '0) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath
   always_comb begin
      sum_in  = sum_ff;
      idx_in  = idx_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      prod_in = prod_ff;
      den_in  = den_ff;
      res_in  = res_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      temp_in = temp_ff;
      oor_in  = oor_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (group_done) begin
                  sum_in  = '0;
                  idx_in  = '0;
                  rem_in  = '0;
                  dvd_in  = {sum_add, {(RES_W - SUM_W){1'b0}}};
                  dsr_in  = ROM_W'(cnt_eff);
                  step_in = AVG_STEPS;
               end else begin
                  sum_in = sum_add;
                  idx_in = idx_add;
               end
            end
         end
         ST_AVG_DIV, ST_RES_DIV: begin
            rem_in  = rem_next;
            dvd_in  = dvd_next;
            step_in = step_ff - STEP_W'(1);
            if (state_ff == ST_RES_DIV && step_ff == '0) res_in = dvd_next;
         end
         ST_SCALE: begin
            // Average at or above the supply pins the reading to the cold end
            if (volt_sat) begin
               res_in  = RES_MAX;
               temp_in = entry_temp('0);
               oor_in  = 1'b1;
            end else begin
               prod_in = PROD_W'(avg[FS_W-1:0]) * PROD_W'(fixed_res_ff);
               den_in  = full_scale_ff - avg[FS_W-1:0];
            end
         end
         ST_OVF: begin
            if (res_ovf) begin
               res_in = RES_MAX;
            end else begin
               rem_in  = ROM_W'(prod_ff[PROD_W-1:RES_W]);
               dvd_in  = prod_ff[RES_W-1:0];
               dsr_in  = ROM_W'(den_ff);
               step_in = RES_STEPS;
            end
         end
         ST_RANGE: begin
            oor_in = 1'b1;
            lo_in  = '0;
            hi_in  = LAST_IDX;
            if (res_ff > RES_W'(ntc_rom('0))) begin
               temp_in = entry_temp('0);
            end else if (res_ff < RES_W'(ntc_rom(LAST_IDX))) begin
               temp_in = entry_temp(LAST_IDX);
            end else begin
               oor_in = 1'b0;
            end
         end
         ST_SEARCH: begin
            if (span > IDX_W'(1)) begin
               if (res_ff < RES_W'(rom_mid)) begin
                  lo_in = mid;
               end else begin
                  hi_in = mid;
               end
            end else begin
               // Fraction = (R_lo - R) * 256 / (R_lo - R_hi), at most 256
               rem_in  = {1'b0, frac_num[ROM_W-1:1]};
               dvd_in  = {frac_num[0], {(RES_W - 1){1'b0}}};
               dsr_in  = rom_lo - rom_hi;
               step_in = FRAC_STEPS;
            end
         end
         ST_FRAC_DIV: begin
            rem_in  = rem_next;
            dvd_in  = dvd_next;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               temp_in = entry_temp(lo_ff) + $signed(TEMP_W'(dvd_next[FRAC_W-1:0]));
            end
         end
         default: ;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_res_ff    <= FIXED_RES_RESET;
         full_scale_ff   <= FULL_SCALE_RESET;
         sample_count_ff <= SAMPLE_COUNT_RESET;
         sum_ff          <= '0;
         idx_ff          <= '0;
         state_ff        <= ST_IDLE;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FIXED_RES:    fixed_res_ff    <= csr_wdata[RES_W-1:0];
               CSR_FULL_SCALE:   full_scale_ff   <= csr_wdata[FS_W-1:0];
               CSR_SAMPLE_COUNT: sample_count_ff <= csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      prod_ff <= prod_in;
      den_ff  <= den_in;
      res_ff  <= res_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      temp_ff <= temp_in;
      oor_ff  <= oor_in;
      if (rsp_load) begin
         rsp_temp_ff <= temp_ff;
         rsp_res_ff  <= res_ff;
         rsp_oor_ff  <= oor_ff;
      end
   end

   // Checks
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= CNT_MAX)
      else $error("sample index beyond group size");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AVG_DIV || state_ff == ST_RES_DIV || state_ff == ST_FRAC_DIV)
      |-> rem_ff < dsr_ff)
      else $error("divider remainder not below divisor");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> lo_ff < hi_ff)
      else $error("search bounds crossed");

   a_in_range_res: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_oor_ff) |-> rsp_res_ff <= RES_W'(ntc_rom('0)))
      else $error("in-range result with resistance above table");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("result load did not return to idle");

endmodule

`default_nettype wire
